// ===== rtl/dtsi_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsi_pkg
// Shared types and constants of the decimal text to signed integer parser.
// ----------------------------------------------------------------------------
package dtsi_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [63:0] LIM_BIG   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] LIM_POS64 = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_DIV10 = 64'd922337203685477580;
    localparam logic [63:0] LIM_POS32 = 64'd2147483647;
    localparam logic [63:0] LIM_NEG32 = 64'd2147483648;

    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PLUS   = 3'd1,
        PH_MINUS  = 3'd2,
        PH_DIGITS = 3'd3,
        PH_TAIL   = 3'd4,
        PH_FAIL   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        logic        syntax_ok;
        logic        negative;
        logic        overflowed;
        logic [63:0] magnitude;
    } t_fin;

endpackage

// ===== rtl/decimal_text_to_signed_int_top.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_signed_int_top
// Parses a streamed ASCII decimal string into a signed 32- or 64-bit integer.
// ----------------------------------------------------------------------------
// Input channel: one string byte per transfer (i_char_byte) with i_last_char
// set on its final byte. A byte can be taken every cycle outside a stall.
// Output channel: one result per string, issued for the byte marked last:
// o_parsed_value (0 on failure) and o_parse_status (ok, invalid, out of range).
// Result path: after the last byte, the result passes the input register,
// the string-end register and the result register, in that order.
// Throughput: one byte per cycle outside a stall; the multiply-by-ten
// and add on the 64-bit magnitude in the parser stage sets that loop.
// Config channel: i_cfg_wide_mode selects 64-bit (1) or 32-bit (0) range; it
// is always ready. Write it only while no string is in flight (not enforced).
// Reset: clears the parser to the start of a string, empties all stages and
// selects 32-bit mode.
// Stall: a stalled receiver holds the result; bytes that are not last keep
// flowing, and a last byte waits once both result stages are full.
// ----------------------------------------------------------------------------
module decimal_text_to_signed_int_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_char_byte,
    input  logic               i_last_char,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_parsed_value,
    output logic [1:0]         o_parse_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_wide_mode
);

    logic           fin_valid;
    logic           fin_ready;
    dtsi_pkg::t_fin fin;

    assign o_cfg_ready = 1'b1;

    dtsi_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_char_byte (i_char_byte),
        .i_last_char (i_last_char),
        .o_fin_valid (fin_valid),
        .i_fin_ready (fin_ready),
        .o_fin       (fin)
    );

    dtsi_range u_range (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_wide_mode (i_cfg_wide_mode),
        .i_fin_valid     (fin_valid),
        .o_fin_ready     (fin_ready),
        .i_fin           (fin),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parsed_value  (o_parsed_value),
        .o_parse_status  (o_parse_status)
    );

endmodule

// ===== rtl/dtsi_parse.sv =====
// ----------------------------------------------------------------------------
// dtsi_parse
// Input register and per-byte parser state: sign, digit accumulation, overflow.
// ----------------------------------------------------------------------------
module dtsi_parse (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_char_byte,
    input  logic           i_last_char,
    output logic           o_fin_valid,
    input  logic           i_fin_ready,
    output dtsi_pkg::t_fin o_fin
);

    logic             r_in_valid;
    logic [7:0]       r_char;
    logic             r_last;
    dtsi_pkg::t_phase r_phase;
    dtsi_pkg::t_phase n_phase;
    logic             r_neg;
    logic             n_neg;
    logic [63:0]      r_mag;
    logic [63:0]      n_mag;
    logic             r_ovf;
    logic             n_ovf;

    logic             fire;
    logic             is_digit;
    logic             is_blank;
    logic             take;
    logic [3:0]       digit;
    logic [63:0]      mag_x10;

    assign fire       = r_in_valid && (!r_last || i_fin_ready);
    assign o_in_ready = !r_in_valid || fire;

    assign is_digit = (r_char >= dtsi_pkg::CH_ZERO) && (r_char <= dtsi_pkg::CH_NINE);
    assign is_blank = (r_char == dtsi_pkg::CH_SPACE) ||
                      ((r_char >= dtsi_pkg::CH_TAB) && (r_char <= dtsi_pkg::CH_CR));
    assign digit    = 4'(r_char - dtsi_pkg::CH_ZERO);
    assign mag_x10  = {r_mag[60:0], 3'b000} + {r_mag[62:0], 1'b0} + {60'd0, digit};

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            dtsi_pkg::PH_START: begin
                if (is_blank) begin
                    n_phase = dtsi_pkg::PH_START;
                end else if (r_char == dtsi_pkg::CH_PLUS) begin
                    n_phase = dtsi_pkg::PH_PLUS;
                end else if (r_char == dtsi_pkg::CH_MINUS) begin
                    n_phase = dtsi_pkg::PH_MINUS;
                end else if (is_digit) begin
                    n_phase = dtsi_pkg::PH_DIGITS;
                end else begin
                    n_phase = dtsi_pkg::PH_FAIL;
                end
            end
            dtsi_pkg::PH_PLUS, dtsi_pkg::PH_MINUS: begin
                n_phase = is_digit ? dtsi_pkg::PH_DIGITS : dtsi_pkg::PH_FAIL;
            end
            dtsi_pkg::PH_DIGITS: begin
                n_phase = is_digit ? dtsi_pkg::PH_DIGITS : dtsi_pkg::PH_TAIL;
            end
            dtsi_pkg::PH_TAIL: begin
                n_phase = dtsi_pkg::PH_TAIL;
            end
            default: begin
                n_phase = dtsi_pkg::PH_FAIL;
            end
        endcase
    end

    always_comb begin
        take  = is_digit && ((r_phase == dtsi_pkg::PH_START) ||
                             (r_phase == dtsi_pkg::PH_PLUS)  ||
                             (r_phase == dtsi_pkg::PH_MINUS) ||
                             (r_phase == dtsi_pkg::PH_DIGITS));
        n_neg = r_neg || ((r_phase == dtsi_pkg::PH_START) && !is_blank &&
                          (r_char == dtsi_pkg::CH_MINUS));
        n_mag = r_mag;
        n_ovf = r_ovf;
        if (take && !r_ovf) begin
            if (r_mag > dtsi_pkg::LIM_DIV10) begin
                n_ovf = 1'b1;
            end else begin
                n_mag = mag_x10;
                n_ovf = mag_x10 > dtsi_pkg::LIM_BIG;
            end
        end
    end

    always_comb begin
        o_fin_valid      = r_in_valid && r_last;
        o_fin.syntax_ok  = (n_phase == dtsi_pkg::PH_DIGITS) || (n_phase == dtsi_pkg::PH_TAIL);
        o_fin.negative   = n_neg;
        o_fin.overflowed = n_ovf;
        o_fin.magnitude  = n_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= dtsi_pkg::PH_START;
            r_neg      <= 1'b0;
            r_mag      <= 64'd0;
            r_ovf      <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                if (r_last) begin
                    r_phase <= dtsi_pkg::PH_START;
                    r_neg   <= 1'b0;
                    r_mag   <= 64'd0;
                    r_ovf   <= 1'b0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_mag   <= n_mag;
                    r_ovf   <= n_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_char <= i_char_byte;
            r_last <= i_last_char;
        end
    end

endmodule

// ===== rtl/dtsi_range.sv =====
// ----------------------------------------------------------------------------
// dtsi_range
// Final string register, range check against the selected width, result register.
// ----------------------------------------------------------------------------
module dtsi_range (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_wide_mode,
    input  logic               i_fin_valid,
    output logic               o_fin_ready,
    input  dtsi_pkg::t_fin     i_fin,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [63:0] o_parsed_value,
    output logic [1:0]         o_parse_status
);

    logic              r_wide_mode;
    logic              r_fin_valid;
    dtsi_pkg::t_fin    r_fin;
    logic              r_out_valid;
    logic [63:0]       r_value;
    dtsi_pkg::t_status r_status;
    logic [63:0]       n_value;
    dtsi_pkg::t_status n_status;
    logic [63:0]       limit;
    logic              out_take;

    assign out_take    = !r_out_valid || i_out_ready;
    assign o_fin_ready = !r_fin_valid || out_take;

    always_comb begin
        if (r_wide_mode) begin
            limit = r_fin.negative ? dtsi_pkg::LIM_BIG : dtsi_pkg::LIM_POS64;
        end else begin
            limit = r_fin.negative ? dtsi_pkg::LIM_NEG32 : dtsi_pkg::LIM_POS32;
        end
        n_value  = 64'd0;
        n_status = dtsi_pkg::ST_INVALID;
        if (r_fin.syntax_ok) begin
            if (r_fin.overflowed || (r_fin.magnitude > limit)) begin
                n_status = dtsi_pkg::ST_RANGE;
            end else begin
                n_status = dtsi_pkg::ST_OK;
                n_value  = r_fin.negative ? (64'd0 - r_fin.magnitude) : r_fin.magnitude;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_mode <= 1'b0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wide_mode <= i_cfg_wide_mode;
            end
            if (o_fin_ready) begin
                r_fin_valid <= i_fin_valid;
            end
            if (out_take) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fin_ready && i_fin_valid) begin
            r_fin <= i_fin;
        end
        if (out_take && r_fin_valid) begin
            r_value  <= n_value;
            r_status <= n_status;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_parsed_value = r_value;
    assign o_parse_status = r_status;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the decimal text to signed integer parser. A short
// table of strings covers blanks, signs, bad leading bytes, zero bytes and the
// 32-bit negative limit. Random well-formed, broken and noise strings follow
// in both widths, with random gaps on the byte and result channels. Each result
// is checked field by field against a built-in parse model.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SETTLE_CYCLES   = 8;
    localparam int BYTES_PER_PHASE = 160;
    localparam int N_PHASES        = 6;

    typedef struct packed {
        logic [63:0]       value;
        dtsi_pkg::t_status status;
    } t_parse_result;

    typedef struct packed {
        logic [7:0]        ch;
        logic              last;
        logic              typed;
        logic [63:0]       value;
        dtsi_pkg::t_status status;
    } t_script_row;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_in_valid      = 1'b0;
    logic [7:0]         i_char_byte     = 8'd0;
    logic               i_last_char     = 1'b0;
    logic               i_out_ready     = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic               i_cfg_wide_mode = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic signed [63:0] o_parsed_value;
    logic [1:0]         o_parse_status;
    logic               o_cfg_ready;

    decimal_text_to_signed_int_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_char_byte     (i_char_byte),
        .i_last_char     (i_last_char),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_parsed_value  (o_parsed_value),
        .o_parse_status  (o_parse_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_wide_mode (i_cfg_wide_mode)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    dtsi_pkg::t_phase scan_phase;
    logic             scan_neg;
    logic             scan_ovf;
    logic             scan_seen;
    logic [63:0]      scan_mag;
    logic             wide_sel = 1'b0;

    t_parse_result awaited_results[$];
    t_script_row   script[$];
    logic [7:0]    text_buf[$];
    int            err_count = 0;
    logic          tx_steady = 1'b0;
    logic          rx_steady = 1'b0;
    int            rx_hold   = 0;
    t_parse_result head_result;

    function automatic int pick_gap(input int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct)
            return 0;
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t: %s mismatch, got %h, want %h", $time, what, got, want);
        err_count++;
    endtask

    task automatic clear_scan();
        scan_phase = dtsi_pkg::PH_START;
        scan_neg   = 1'b0;
        scan_ovf   = 1'b0;
        scan_seen  = 1'b0;
        scan_mag   = '0;
    endtask

    task automatic add_digit(input logic [7:0] c);
        scan_seen = 1'b1;
        if (!scan_ovf) begin
            if (scan_mag > dtsi_pkg::LIM_DIV10) begin
                scan_ovf = 1'b1;
            end else begin
                scan_mag = scan_mag * 64'd10 + {56'd0, c - dtsi_pkg::CH_ZERO};
                if (scan_mag > dtsi_pkg::LIM_BIG)
                    scan_ovf = 1'b1;
            end
        end
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic last,
                             output logic emits, output t_parse_result res);
        logic [63:0] limit;
        logic        blank;
        logic        digit;
        blank = (c == dtsi_pkg::CH_SPACE) ||
                (c >= dtsi_pkg::CH_TAB && c <= dtsi_pkg::CH_CR);
        digit = (c >= dtsi_pkg::CH_ZERO) && (c <= dtsi_pkg::CH_NINE);
        case (scan_phase)
            dtsi_pkg::PH_START: begin
                if (!blank) begin
                    if (c == dtsi_pkg::CH_PLUS) begin
                        scan_phase = dtsi_pkg::PH_PLUS;
                    end else if (c == dtsi_pkg::CH_MINUS) begin
                        scan_phase = dtsi_pkg::PH_MINUS;
                        scan_neg   = 1'b1;
                    end else if (digit) begin
                        scan_phase = dtsi_pkg::PH_DIGITS;
                        add_digit(c);
                    end else begin
                        scan_phase = dtsi_pkg::PH_FAIL;
                    end
                end
            end
            dtsi_pkg::PH_PLUS, dtsi_pkg::PH_MINUS: begin
                if (digit) begin
                    scan_phase = dtsi_pkg::PH_DIGITS;
                    add_digit(c);
                end else begin
                    scan_phase = dtsi_pkg::PH_FAIL;
                end
            end
            dtsi_pkg::PH_DIGITS: begin
                if (digit)
                    add_digit(c);
                else
                    scan_phase = dtsi_pkg::PH_TAIL;
            end
            dtsi_pkg::PH_TAIL: ;
            default: scan_phase = dtsi_pkg::PH_FAIL;
        endcase
        emits      = last;
        res.value  = '0;
        res.status = dtsi_pkg::ST_INVALID;
        if (last) begin
            if ((scan_phase == dtsi_pkg::PH_DIGITS || scan_phase == dtsi_pkg::PH_TAIL) &&
                scan_seen) begin
                if (wide_sel)
                    limit = scan_neg ? dtsi_pkg::LIM_BIG : dtsi_pkg::LIM_POS64;
                else
                    limit = scan_neg ? dtsi_pkg::LIM_NEG32 : dtsi_pkg::LIM_POS32;
                if (scan_ovf || scan_mag > limit) begin
                    res.status = dtsi_pkg::ST_RANGE;
                end else begin
                    res.status = dtsi_pkg::ST_OK;
                    res.value  = scan_neg ? 64'd0 - scan_mag : scan_mag;
                end
            end
            clear_scan();
        end
    endtask

    task automatic send_byte(input logic [7:0] c, input logic last, input logic typed,
                             input logic [63:0] typed_value,
                             input dtsi_pkg::t_status typed_status);
        int            gap;
        logic          emits;
        t_parse_result res;
        gap = tx_steady ? 0 : pick_gap(40);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_byte <= c;
        i_last_char <= last;
        do @(posedge i_clk); while (!o_in_ready);
        scan_byte(c, last, emits, res);
        if (emits) begin
            if (typed) begin
                res.value  = typed_value;
                res.status = typed_status;
            end
            awaited_results.push_back(res);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_width(input logic wide);
        wait_drained();
        i_cfg_valid     <= 1'b1;
        i_cfg_wide_mode <= wide;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        wide_sel = wide;
    endtask

    task automatic add_row(input logic [7:0] ch, input logic last, input logic typed,
                           input logic [63:0] value, input dtsi_pkg::t_status status);
        t_script_row row;
        row.ch     = ch;
        row.last   = last;
        row.typed  = typed;
        row.value  = value;
        row.status = status;
        script.push_back(row);
    endtask

    task automatic add_text(input string s, input logic closes, input logic typed,
                            input logic [63:0] value, input dtsi_pkg::t_status status);
        for (int i = 0; i < s.len(); i++)
            add_row(s[i], closes && i == s.len() - 1, typed, value, status);
    endtask

    task automatic put_blanks(input int n);
        int r;
        repeat (n) begin
            r = $urandom_range(0, 5);
            text_buf.push_back(r == 5 ? dtsi_pkg::CH_SPACE : dtsi_pkg::CH_TAB + 8'(r));
        end
    endtask

    task automatic put_number(input logic [63:0] m);
        logic [7:0] dg [0:19];
        int         n;
        n = 0;
        do begin
            dg[n] = dtsi_pkg::CH_ZERO + 8'(m % 64'd10);
            m     = m / 64'd10;
            n++;
        end while (m != 0);
        for (int i = n - 1; i >= 0; i--)
            text_buf.push_back(dg[i]);
    endtask

    task automatic build_string();
        int          kind;
        int          r;
        logic [63:0] m;
        logic [7:0]  b;
        text_buf.delete();
        kind = $urandom_range(0, 99);
        put_blanks($urandom_range(0, 2));
        if (kind < 70) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                text_buf.push_back(dtsi_pkg::CH_MINUS);
            else if (r < 50)
                text_buf.push_back(dtsi_pkg::CH_PLUS);
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3)) text_buf.push_back(dtsi_pkg::CH_ZERO);
            case ($urandom_range(0, 8))
                0, 1, 2: m = $urandom_range(0, 999);
                3:       m = dtsi_pkg::LIM_POS32 - 2 + $urandom_range(0, 4);
                4:       m = dtsi_pkg::LIM_NEG32 - 2 + $urandom_range(0, 4);
                5:       m = dtsi_pkg::LIM_POS64 - 2 + $urandom_range(0, 4);
                6:       m = {$urandom, $urandom};
                7:       m = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 9);
                default: m = $urandom;
            endcase
            put_number(m);
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 4))
                    text_buf.push_back(dtsi_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 99) < 30)
                repeat ($urandom_range(1, 3)) text_buf.push_back(8'($urandom_range(0, 255)));
        end else if (kind < 85) begin
            case ($urandom_range(0, 4))
                0: begin
                    text_buf.push_back(dtsi_pkg::CH_PLUS);
                    text_buf.push_back(dtsi_pkg::CH_MINUS);
                end
                1: begin
                    text_buf.push_back(dtsi_pkg::CH_PLUS);
                    text_buf.push_back(dtsi_pkg::CH_PLUS);
                end
                2: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b >= dtsi_pkg::CH_ZERO && b <= dtsi_pkg::CH_NINE);
                    text_buf.push_back($urandom_range(0, 1) ? dtsi_pkg::CH_MINUS
                                                            : dtsi_pkg::CH_PLUS);
                    text_buf.push_back(b);
                end
                3: text_buf.push_back($urandom_range(0, 1) ? dtsi_pkg::CH_MINUS
                                                           : dtsi_pkg::CH_PLUS);
                default: put_blanks(1);
            endcase
            if ($urandom_range(0, 1))
                put_number($urandom_range(0, 99));
        end else begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
        end
        if (text_buf.size() == 0)
            text_buf.push_back(dtsi_pkg::CH_SPACE);
    endtask

    always @(posedge i_clk) begin : rx_side
        int draw;
        if (rx_hold > 0) begin
            i_out_ready <= 1'b0;
            rx_hold     <= rx_hold - 1;
        end else begin
            draw = rx_steady ? 0 : pick_gap(20);
            i_out_ready <= (draw == 0);
            rx_hold     <= (draw > 0) ? draw - 1 : 0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                note_mismatch("unexpected result", o_parsed_value, '0);
            end else begin
                head_result = awaited_results.pop_front();
                if (o_parsed_value !== head_result.value)
                    note_mismatch("parsed_value", o_parsed_value, head_result.value);
                if (o_parse_status !== head_result.status)
                    note_mismatch("parse_status", {62'd0, o_parse_status},
                                  {62'd0, head_result.status});
            end
        end
    end

    initial begin
        int   sent;
        logic open;
        clear_scan();
        add_text("0", 1'b1, 1'b1, 64'd0, dtsi_pkg::ST_OK);
        add_row(8'h00, 1'b1, 1'b1, 64'd0, dtsi_pkg::ST_INVALID);
        add_text("+-", 1'b1, 1'b1, 64'd0, dtsi_pkg::ST_INVALID);
        add_row(8'hFF, 1'b1, 1'b1, 64'd0, dtsi_pkg::ST_INVALID);
        add_row(dtsi_pkg::CH_CR, 1'b0, 1'b0, '0, dtsi_pkg::ST_OK);
        add_text("+5 ", 1'b1, 1'b0, '0, dtsi_pkg::ST_OK);
        add_text("7", 1'b0, 1'b0, '0, dtsi_pkg::ST_OK);
        add_row(8'h00, 1'b0, 1'b0, '0, dtsi_pkg::ST_OK);
        add_text("5", 1'b1, 1'b0, '0, dtsi_pkg::ST_OK);
        add_text("-0", 1'b1, 1'b1, 64'd0, dtsi_pkg::ST_OK);
        add_text("-2147483648", 1'b1, 1'b1, 64'hFFFF_FFFF_8000_0000, dtsi_pkg::ST_OK);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[i])
            send_byte(script[i].ch, script[i].last, script[i].typed,
                      script[i].value, script[i].status);

        for (int p = 0; p < N_PHASES; p++) begin
            write_width(p < 4 ? (p % 2 == 0) : 1'($urandom_range(0, 1)));
            tx_steady = (p == 0) || ($urandom_range(0, 3) == 0);
            rx_steady <= (p == 0) || ($urandom_range(0, 3) == 0);
            sent = 0;
            open = 1'b0;
            while (sent < BYTES_PER_PHASE || open) begin
                build_string();
                // leave a piece unterminated now and then; a later one closes it
                open = (sent < BYTES_PER_PHASE) && ($urandom_range(0, 19) == 0);
                foreach (text_buf[k])
                    send_byte(text_buf[k], !open && k == text_buf.size() - 1,
                              1'b0, '0, dtsi_pkg::ST_OK);
                sent += text_buf.size();
                if (!open && $urandom_range(0, 19) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
